/* sv/edfts_pkg.sv */
// Shared constants, types and helper functions of the EDF tick scheduler.
package edfts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int TIME_BITS = 32;
    localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // One task entry as it sits in the task memory.
    typedef struct packed {
        logic [15:0]          period;
        logic [7:0]           wcet;
        logic [7:0]           work_left;
        logic [TIME_BITS-1:0] abs_deadline;
        logic [TIME_BITS-1:0] next_release;
    } task_entry_t;

    // Control group from the sequencer to the task memory.
    typedef struct packed {
        logic              we;
        logic [TASK_W-1:0] waddr;
        logic [TASK_W-1:0] raddr;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RST_RD,
        ST_RST_WR,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_UPDATE,
        ST_RESP
    } state_t;

    // Saturating add of a period to a time value.
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [15:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + (TIME_BITS+1)'(b);
        return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

    // Entry of a task whose first job is released at time zero.
    function automatic task_entry_t first_job(input logic [15:0] period,
                                              input logic [7:0] wcet);
        task_entry_t e;
        logic        en;
        en             = (period != 16'd0) && (wcet != 8'd0);
        e.period       = period;
        e.wcet         = wcet;
        e.work_left    = en ? wcet : 8'd0;
        e.abs_deadline = en ? TIME_BITS'(period) : '0;
        e.next_release = '0;
        return e;
    endfunction

endpackage

/* sv/edfts_task_ram.sv */
// Task table memory with per-entry valid bits; unwritten entries read as zero.
module edfts_task_ram (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  edfts_pkg::mem_ctl_t    ctl,
    input  edfts_pkg::task_entry_t wdata,
    output edfts_pkg::task_entry_t rdata
);

    edfts_pkg::task_entry_t mem [edfts_pkg::NUM_TASKS];

    logic [edfts_pkg::NUM_TASKS-1:0] valid_reg;
    edfts_pkg::task_entry_t          rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.we) begin
            valid_reg[ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= wdata;
        end
    end

    // A read of the entry being written in the same cycle returns its previous contents.
    always_ff @(posedge aclk) begin
        if (valid_reg[ctl.raddr]) begin
            rdata_reg <= mem[ctl.raddr];
        end else begin
            rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/edf_tick_scheduler.sv */
// Top level of the earliest-deadline-first tick scheduler.
//
// The block keeps a table of periodic tasks (deadline equal to period) in a
// small synchronous memory and answers every request with exactly one
// result. The request kind travels in s_tuser: load writes one task entry
// and releases its first job at time zero, restart sets time to zero, clears
// the failed mark and restarts the first job of every task, and tick picks
// the released job with work left and the earliest absolute deadline (the
// lowest index wins ties), runs it one tick and rearms it at its next period
// when its work is done. Any other kind only reports the current state.
// Requests are handled one at a time: the tick scan reads one task entry
// per cycle through the memory read port, and a restart reads each entry
// and then writes it back. A result waits in an output register, so the
// next request is taken while the previous result is still pending on the
// master side. Time saturates at its largest value, which sets the failed
// mark.
module edf_tick_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // opcode
    input  logic [31:0] s_tdata,   // task_index[2:0], task_period[18:3], task_wcet[26:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // tick_time[31:0], run_task[34:32], idle[35],
                                   // missed[36], job_finished[37], failed[38]
);

    localparam int TB = edfts_pkg::TIME_BITS;
    localparam int TW = edfts_pkg::TASK_W;
    localparam logic [TW-1:0] LAST_TASK = TW'(edfts_pkg::NUM_TASKS - 1);

    edfts_pkg::state_t state_reg, state_next;

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] period_reg, period_next;
    logic [7:0]  wcet_reg, wcet_next;

    logic [TB-1:0] now_reg, now_next;
    logic          fail_reg, fail_next;

    logic [TW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [TW-1:0] eval_idx_reg, eval_idx_next;

    logic                   found_reg, found_next;
    logic [TW-1:0]          best_idx_reg, best_idx_next;
    edfts_pkg::task_entry_t best_reg, best_next;

    logic [31:0] res_time_reg, res_time_next;
    logic [2:0]  res_run_reg, res_run_next;
    logic        res_idle_reg, res_idle_next;
    logic        res_missed_reg, res_missed_next;
    logic        res_fin_reg, res_fin_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    edfts_pkg::mem_ctl_t    mem_ctl;
    edfts_pkg::task_entry_t mem_wdata;
    edfts_pkg::task_entry_t mem_rdata;
    edfts_pkg::task_entry_t upd_entry;

    logic s_fire;
    logic cand_ready;
    logic cand_take;
    logic out_free;

    edfts_task_ram u_task_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

    assign s_tready = (state_reg == edfts_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // A scanned entry competes when its job is released and has work left.
    assign cand_ready = (mem_rdata.work_left != 8'd0) && (mem_rdata.next_release <= now_reg);
    assign cand_take  = cand_ready &&
                        (!found_reg || (mem_rdata.abs_deadline < best_reg.abs_deadline));

    // Entry of the chosen job after it has run for one tick.
    always_comb begin
        upd_entry           = best_reg;
        upd_entry.work_left = best_reg.work_left - 8'd1;
        if (best_reg.work_left == 8'd1) begin
            upd_entry.work_left    = best_reg.wcet;
            upd_entry.next_release = edfts_pkg::sat_add(best_reg.next_release, best_reg.period);
            upd_entry.abs_deadline = edfts_pkg::sat_add(best_reg.abs_deadline, best_reg.period);
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        period_next     = period_reg;
        wcet_next       = wcet_reg;
        now_next        = now_reg;
        fail_next       = fail_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        eval_idx_next   = cnt_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_time_next   = res_time_reg;
        res_run_next    = res_run_reg;
        res_idle_next   = res_idle_reg;
        res_missed_next = res_missed_reg;
        res_fin_next    = res_fin_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        mem_ctl.we    = 1'b0;
        mem_ctl.waddr = cnt_reg;
        mem_ctl.raddr = cnt_reg;
        mem_wdata     = edfts_pkg::first_job(mem_rdata.period, mem_rdata.wcet);

        case (state_reg)
            edfts_pkg::ST_IDLE: begin
                if (s_fire) begin
                    idx_next        = s_tdata[2:0];
                    period_next     = s_tdata[18:3];
                    wcet_next       = s_tdata[26:19];
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    res_time_next   = 32'(now_reg);
                    res_run_next    = 3'd0;
                    res_idle_next   = 1'b1;
                    res_missed_next = 1'b0;
                    res_fin_next    = 1'b0;
                    case (s_tuser)
                        edfts_pkg::OP_LOAD: begin
                            state_next = edfts_pkg::ST_LOAD;
                        end
                        edfts_pkg::OP_RESTART: begin
                            now_next      = '0;
                            fail_next     = 1'b0;
                            res_time_next = 32'd0;
                            state_next    = edfts_pkg::ST_RST_RD;
                        end
                        edfts_pkg::OP_TICK: begin
                            state_next = edfts_pkg::ST_SCAN;
                        end
                        default: begin
                            state_next = edfts_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            edfts_pkg::ST_LOAD: begin
                mem_ctl.we    = (int'(idx_reg) < edfts_pkg::NUM_TASKS);
                mem_ctl.waddr = TW'(idx_reg);
                mem_wdata     = edfts_pkg::first_job(period_reg, wcet_reg);
                state_next    = edfts_pkg::ST_RESP;
            end

            edfts_pkg::ST_RST_RD: begin
                state_next = edfts_pkg::ST_RST_WR;
            end

            edfts_pkg::ST_RST_WR: begin
                mem_ctl.we = 1'b1;
                cnt_next   = cnt_reg + TW'(1);
                if (cnt_reg == LAST_TASK) begin
                    state_next = edfts_pkg::ST_RESP;
                end else begin
                    state_next = edfts_pkg::ST_RST_RD;
                end
            end

            edfts_pkg::ST_SCAN, edfts_pkg::ST_SCAN_LAST: begin
                // Read entry cnt this cycle, judge the entry read in the previous cycle.
                if (pend_reg && cand_take) begin
                    found_next    = 1'b1;
                    best_idx_next = eval_idx_reg;
                    best_next     = mem_rdata;
                end
                if (state_reg == edfts_pkg::ST_SCAN) begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + TW'(1);
                    if (cnt_reg == LAST_TASK) begin
                        state_next = edfts_pkg::ST_SCAN_LAST;
                    end
                end else begin
                    state_next = edfts_pkg::ST_UPDATE;
                end
            end

            edfts_pkg::ST_UPDATE: begin
                if (found_reg) begin
                    mem_ctl.we      = 1'b1;
                    mem_ctl.waddr   = best_idx_reg;
                    mem_wdata       = upd_entry;
                    res_run_next    = 3'(best_idx_reg);
                    res_idle_next   = 1'b0;
                    res_fin_next    = (best_reg.work_left == 8'd1);
                    res_missed_next = (now_reg >= best_reg.abs_deadline);
                    if (now_reg >= best_reg.abs_deadline) begin
                        fail_next = 1'b1;
                    end
                end
                if (now_reg == edfts_pkg::TIME_MAX) begin
                    fail_next = 1'b1;
                end else begin
                    now_next = now_reg + TB'(1);
                end
                state_next = edfts_pkg::ST_RESP;
            end

            edfts_pkg::ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, fail_reg, res_fin_reg, res_missed_reg,
                                     res_idle_reg, res_run_reg, res_time_reg};
                    state_next    = edfts_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = edfts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= edfts_pkg::ST_IDLE;
            now_reg      <= '0;
            fail_reg     <= 1'b0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            fail_reg     <= fail_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        period_reg     <= period_next;
        wcet_reg       <= wcet_next;
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_time_reg   <= res_time_next;
        res_run_reg    <= res_run_next;
        res_idle_reg   <= res_idle_next;
        res_missed_reg <= res_missed_next;
        res_fin_reg    <= res_fin_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
